@@ rtl/core/bmp8m_pkg.sv @@
// bmp8m_pkg: shared constants, phase type and stage structs for the bmp8 mono stream
// used by bmp8m_parse and bmp8_to_mono_pixel_stream; depends on nothing
`timescale 1ns / 1ps

package bmp8m_pkg;

  localparam int unsigned SCREEN_WIDTH  = 64;
  localparam int unsigned SCREEN_HEIGHT = 48;
  localparam int unsigned PALETTE_DEPTH = 256;

  localparam logic [15:0] BMP_TYPE        = 16'h4D42;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd127;
  localparam logic [8:0]  PALETTE_FULL    = 9'd256;
  localparam logic [31:0] HEADER_BYTES    = 32'd54;

  // byte positions of the last byte of each checked or captured header field, and of the header
  localparam logic [31:0] POS_TYPE    = 32'd1;
  localparam logic [31:0] POS_OFFSET  = 32'd13;
  localparam logic [31:0] POS_WIDTH   = 32'd21;
  localparam logic [31:0] POS_HEIGHT  = 32'd25;
  localparam logic [31:0] POS_DEPTH   = 32'd29;
  localparam logic [31:0] POS_COMPR   = 32'd33;
  localparam logic [31:0] POS_COLOURS = 32'd49;
  localparam logic [31:0] POS_LAST    = 32'd53;

  localparam logic [15:0] DEPTH_8BIT = 16'd8;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned PTR_W     = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W     = PTR_W + 1;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_SKIP,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] x;
    logic [5:0] y;
  } event_t;

  typedef struct packed {
    logic   busy;
    logic   push;
    event_t evt;
  } stage_t;

endpackage

@@ rtl/core/bmp8m_parse.sv @@
// bmp8m_parse: header/palette/pixel parser with dark-bit palette store and lookup stage
// depends on bmp8m_pkg
`timescale 1ns / 1ps

module bmp8m_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [7:0]            cfg_data,
  input  logic                  in_accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_file,
  output bmp8m_pkg::stage_t     stage
);

  bmp8m_pkg::phase_t phase, phase_next;

  logic [31:0] byte_position, byte_position_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] pixel_data_offset, pixel_data_offset_next;
  logic [6:0]  image_width, image_width_next;
  logic [5:0]  image_height, image_height_next;
  logic [8:0]  palette_count, palette_count_next;
  logic [9:0]  colour_sum, colour_sum_next;
  logic [6:0]  column_count, column_count_next;
  logic [5:0]  row_count, row_count_next;
  logic        header_ok, header_ok_next;
  logic [7:0]  dark_threshold;

  logic        dark_mem [bmp8m_pkg::PALETTE_DEPTH];
  logic        dark_q;

  logic        p1_busy;
  logic        p1_kind;
  logic [5:0]  p1_x;
  logic [5:0]  p1_y;

  logic        cand_valid;
  logic        cand_kind;
  logic [5:0]  cand_x;
  logic [5:0]  cand_y;

  logic [31:0] bp_inc;
  logic [31:0] rel;
  logic [1:0]  pal_part;
  logic [7:0]  pal_entry;
  logic        pal_last;
  logic [9:0]  sum_in;
  logic [9:0]  thr3;
  logic        entry_dark;
  logic        pal_write;
  logic        ok_after;
  logic        type_bad;
  logic [6:0]  padded;
  logic [6:0]  col_inc;
  logic [5:0]  row_inc;
  logic        row_done;
  logic        pix_cand;
  logic [6:0]  x_off;
  logic [6:0]  y_off;
  logic [6:0]  x_full;
  logic [6:0]  y_full;

  function automatic logic size_fits(input logic [31:0] v, input logic [31:0] limit);
    size_fits = !v[31] && (v != 32'd0) && (v <= limit);
  endfunction

  // shared datapath terms
  always_comb begin
    field_shift_next = {data_byte, field_shift[31:8]};
    bp_inc     = byte_position + 32'd1;
    rel        = byte_position - bmp8m_pkg::HEADER_BYTES;
    pal_part   = rel[1:0];
    pal_entry  = rel[9:2];
    pal_last   = (9'({1'b0, pal_entry} + 9'd1) >= palette_count);
    sum_in     = (pal_part == 2'd0) ? {2'b00, data_byte} : colour_sum + {2'b00, data_byte};
    thr3       = {1'b0, dark_threshold, 1'b0} + {2'b00, dark_threshold};
    entry_dark = (sum_in < thr3);
    type_bad   = (byte_position == bmp8m_pkg::POS_TYPE) &&
                 (field_shift_next[31:16] != bmp8m_pkg::BMP_TYPE);
    padded     = (image_width + 7'd3) & ~7'd3;
    col_inc    = column_count + 7'd1;
    row_inc    = row_count + 6'd1;
    row_done   = (col_inc >= padded);
    pix_cand   = (column_count < image_width) && ({1'b0, data_byte} < palette_count);
    x_off      = (7'(bmp8m_pkg::SCREEN_WIDTH) - image_width) >> 1;
    y_off      = (7'(bmp8m_pkg::SCREEN_HEIGHT) - {1'b0, image_height}) >> 1;
    x_full     = column_count + x_off;
    y_full     = 7'(bmp8m_pkg::SCREEN_HEIGHT - 1) - ({1'b0, row_count} + y_off);
    pal_write  = in_accept && (phase == bmp8m_pkg::PH_PALETTE) && (pal_part == 2'd2);
  end

  // header check accumulation
  always_comb begin
    ok_after = header_ok;
    if (byte_position == bmp8m_pkg::POS_WIDTH) begin
      ok_after = header_ok && size_fits(field_shift_next, 32'(bmp8m_pkg::SCREEN_WIDTH));
    end
    if (byte_position == bmp8m_pkg::POS_HEIGHT) begin
      ok_after = header_ok && size_fits(field_shift_next, 32'(bmp8m_pkg::SCREEN_HEIGHT));
    end
    if (byte_position == bmp8m_pkg::POS_DEPTH) begin
      ok_after = header_ok && (field_shift_next[31:16] == bmp8m_pkg::DEPTH_8BIT);
    end
    if (byte_position == bmp8m_pkg::POS_COMPR) begin
      ok_after = header_ok && (field_shift_next == 32'd0);
    end
    if (byte_position == bmp8m_pkg::POS_COLOURS) begin
      ok_after = header_ok && (field_shift_next < 32'd256);
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      bmp8m_pkg::PH_HEADER: begin
        if (type_bad) begin
          phase_next = bmp8m_pkg::PH_IDLE;
        end else if (byte_position == bmp8m_pkg::POS_LAST) begin
          phase_next = header_ok ? bmp8m_pkg::PH_PALETTE : bmp8m_pkg::PH_IDLE;
        end
      end
      bmp8m_pkg::PH_PALETTE: begin
        if (pal_part == 2'd3 && pal_last) begin
          phase_next = (bp_inc >= pixel_data_offset) ? bmp8m_pkg::PH_PIXELS
                                                     : bmp8m_pkg::PH_SKIP;
        end
      end
      bmp8m_pkg::PH_SKIP: begin
        if (bp_inc >= pixel_data_offset) begin
          phase_next = bmp8m_pkg::PH_PIXELS;
        end
      end
      bmp8m_pkg::PH_PIXELS: begin
        if (row_done && row_inc >= image_height) begin
          phase_next = bmp8m_pkg::PH_IDLE;
        end
      end
      bmp8m_pkg::PH_IDLE: begin
        phase_next = bmp8m_pkg::PH_IDLE;
      end
      default: begin
        phase_next = bmp8m_pkg::PH_IDLE;
      end
    endcase
    if (end_of_file) begin
      phase_next = bmp8m_pkg::PH_HEADER;
    end
  end

  // datapath next values and result candidate
  always_comb begin
    byte_position_next     = byte_position;
    pixel_data_offset_next = pixel_data_offset;
    image_width_next       = image_width;
    image_height_next      = image_height;
    palette_count_next     = palette_count;
    colour_sum_next        = colour_sum;
    column_count_next      = column_count;
    row_count_next         = row_count;
    header_ok_next         = header_ok;
    cand_valid             = 1'b0;
    cand_kind              = bmp8m_pkg::KIND_PIXEL;
    cand_x                 = 6'd0;
    cand_y                 = 6'd0;
    case (phase)
      bmp8m_pkg::PH_HEADER: begin
        byte_position_next = bp_inc;
        header_ok_next     = ok_after;
        if (byte_position == bmp8m_pkg::POS_OFFSET) begin
          pixel_data_offset_next = field_shift_next;
        end
        if (byte_position == bmp8m_pkg::POS_WIDTH) begin
          image_width_next = field_shift_next[6:0];
        end
        if (byte_position == bmp8m_pkg::POS_HEIGHT) begin
          image_height_next = field_shift_next[5:0];
        end
        if (byte_position == bmp8m_pkg::POS_COLOURS) begin
          palette_count_next = (field_shift_next != 32'd0 && field_shift_next < 32'd256)
                               ? field_shift_next[8:0] : bmp8m_pkg::PALETTE_FULL;
        end
        if (!type_bad && byte_position == bmp8m_pkg::POS_LAST) begin
          if (!header_ok) begin
            cand_valid = 1'b1;
            cand_kind  = bmp8m_pkg::KIND_REJECT;
          end else begin
            colour_sum_next = 10'd0;
          end
        end
      end
      bmp8m_pkg::PH_PALETTE: begin
        byte_position_next = bp_inc;
        if (pal_part != 2'd3) begin
          colour_sum_next = sum_in;
        end
        if (pal_part == 2'd3 && pal_last) begin
          column_count_next = 7'd0;
          row_count_next    = 6'd0;
        end
      end
      bmp8m_pkg::PH_SKIP: begin
        byte_position_next = bp_inc;
      end
      bmp8m_pkg::PH_PIXELS: begin
        cand_valid        = pix_cand;
        cand_x            = x_full[5:0];
        cand_y            = y_full[5:0];
        column_count_next = col_inc;
        if (row_done) begin
          column_count_next = 7'd0;
          row_count_next    = row_inc;
        end
      end
      default: begin
        byte_position_next = byte_position;
      end
    endcase
    if (end_of_file) begin
      byte_position_next     = 32'd0;
      pixel_data_offset_next = 32'd0;
      image_width_next       = 7'd0;
      image_height_next      = 6'd0;
      palette_count_next     = bmp8m_pkg::PALETTE_FULL;
      colour_sum_next        = 10'd0;
      column_count_next      = 7'd0;
      row_count_next         = 6'd0;
      header_ok_next         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= bmp8m_pkg::PH_HEADER;
      byte_position     <= 32'd0;
      field_shift       <= 32'd0;
      pixel_data_offset <= 32'd0;
      image_width       <= 7'd0;
      image_height      <= 6'd0;
      palette_count     <= bmp8m_pkg::PALETTE_FULL;
      colour_sum        <= 10'd0;
      column_count      <= 7'd0;
      row_count         <= 6'd0;
      header_ok         <= 1'b1;
    end else if (in_accept) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      field_shift       <= end_of_file ? 32'd0 :
                           (phase == bmp8m_pkg::PH_HEADER) ? field_shift_next : field_shift;
      pixel_data_offset <= pixel_data_offset_next;
      image_width       <= image_width_next;
      image_height      <= image_height_next;
      palette_count     <= palette_count_next;
      colour_sum        <= colour_sum_next;
      column_count      <= column_count_next;
      row_count         <= row_count_next;
      header_ok         <= header_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold <= bmp8m_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      dark_threshold <= cfg_data;
    end
  end

  // palette dark-bit store
  always_ff @(posedge clk) begin
    if (pal_write) begin
      dark_mem[pal_entry] <= entry_dark;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      dark_q <= dark_mem[data_byte];
    end
  end

  // lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_busy <= 1'b0;
    end else begin
      p1_busy <= in_accept && cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_kind <= cand_kind;
      p1_x    <= cand_x;
      p1_y    <= cand_y;
    end
  end

  always_comb begin
    stage.busy     = p1_busy;
    stage.push     = p1_busy && (p1_kind || dark_q);
    stage.evt.kind = p1_kind;
    stage.evt.x    = p1_x;
    stage.evt.y    = p1_y;
  end

  ap_reject_zero: assert property (@(posedge clk) disable iff (rst)
    stage.push && stage.evt.kind |-> stage.evt.x == 6'd0 && stage.evt.y == 6'd0)
    else $error("reject item carries a coordinate");

  ap_busy_from_accept: assert property (@(posedge clk) disable iff (rst)
    stage.busy |-> $past(in_accept))
    else $error("lookup stage busy without an accepted item");

  ap_push_needs_busy: assert property (@(posedge clk) disable iff (rst)
    stage.push |-> stage.busy)
    else $error("result pushed from an empty lookup stage");

endmodule

@@ rtl/core/bmp8_to_mono_pixel_stream.sv @@
// bmp8_to_mono_pixel_stream: top level, byte input, threshold register, result queue
// depends on bmp8m_pkg and bmp8m_parse
//
//   channel   signals                                     direction
//   input     in_valid in_stall data_byte end_of_file     bytes in
//   output    out_valid out_stall event_kind pixel_x/y    pixel or reject items out
//   config    cfg_valid cfg_ready dark_threshold          threshold writes in
//
// one byte per cycle while in_stall is low; a result passes the lookup stage (palette read) and the result queue
// a four-entry result queue absorbs output stalls; in_stall rises when the queue
// plus the lookup stage hold four items
// synchronous reset clears the parser, queue and threshold (127); palette store is not cleared
`timescale 1ns / 1ps

module bmp8_to_mono_pixel_stream (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       event_kind,
  output logic [5:0] pixel_x,
  output logic [5:0] pixel_y,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] dark_threshold
);

  bmp8m_pkg::stage_t stage;
  bmp8m_pkg::event_t queue [bmp8m_pkg::OUT_DEPTH];

  logic [bmp8m_pkg::PTR_W-1:0] wr_ptr;
  logic [bmp8m_pkg::PTR_W-1:0] rd_ptr;
  logic [bmp8m_pkg::CNT_W-1:0] count, count_next;
  logic                        in_accept;
  logic                        pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count + bmp8m_pkg::CNT_W'(stage.busy)) >=
                     bmp8m_pkg::CNT_W'(bmp8m_pkg::OUT_DEPTH);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;

  bmp8m_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (dark_threshold),
    .in_accept   (in_accept),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .stage       (stage)
  );

  always_comb begin
    count_next = count + bmp8m_pkg::CNT_W'(stage.push) - bmp8m_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (stage.push) begin
        wr_ptr <= wr_ptr + bmp8m_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bmp8m_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.push) begin
      queue[wr_ptr] <= stage.evt;
    end
  end

  assign event_kind = queue[rd_ptr].kind;
  assign pixel_x    = queue[rd_ptr].x;
  assign pixel_y    = queue[rd_ptr].y;

  ap_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bmp8m_pkg::CNT_W'(bmp8m_pkg::OUT_DEPTH))
    else $error("result queue count out of range");

  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stage.push && !pop |-> count < bmp8m_pkg::CNT_W'(bmp8m_pkg::OUT_DEPTH))
    else $error("result pushed into a full queue");

  ap_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> count == '0 && !stage.busy)
    else $error("queue or lookup stage not empty after reset");

endmodule
